/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for the concurrent checks of the frame store engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on a named clock with an active-low reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on the block clock and reset
`define ASSERT_STD(lbl, prop, msg) \
    `ASSERT_CLKD(lbl, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/mpfe_pkg.sv */
// ----------------------------------------------------------------------------
// mpfe_pkg
// geometry, codes and control types of the page-mode frame store engine
// ----------------------------------------------------------------------------
package mpfe_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;

    localparam int PAGE_ROWS   = 8;
    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int STORE_DEPTH = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // refresh stream: three command slots then one slot per column
    localparam int CMD_SLOTS  = 3;
    localparam int SLOT_COUNT = CMD_SLOTS + DISPLAY_WIDTH;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam int PCT_W  = 7;
    localparam int PROD_W = 8 + PCT_W;

    localparam logic [7:0]       PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0]       COL_LOW_CMD   = 8'h00;
    localparam logic [7:0]       COL_HIGH_CMD  = 8'h10;
    localparam logic [PCT_W-1:0] FULL_PERCENT  = 7'd100;

    // command codes
    localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [2:0] CMD_CLR_PIXEL = 3'd1;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd2;
    localparam logic [2:0] CMD_BAR       = 3'd3;
    localparam logic [2:0] CMD_NEXT_BYTE = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       clip;
        logic       prod;
        logic       mem_rd;
        logic       mem_wr;
        logic       ref_out;
        logic [2:0] op;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pix_ok;
        logic bar_ok;
        logic clr_last;
        logic bar_last;
    } t_dp_status;

endpackage

/* rtl/mpfe_datapath.sv */
// ----------------------------------------------------------------------------
// mpfe_datapath
// frame store memory, item registers, bar walk and refresh position
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpfe_datapath import mpfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_bar_width,
    input  logic [7:0] i_bar_height,
    input  logic [7:0] i_fill_percent,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_end,
    output logic       o_valid
);

    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_rd_data;

    logic [7:0] r_x, r_y, r_w, r_h, r_pct;
    logic [7:0] r_x_end, r_y_end;
    logic [PROD_W-1:0] r_prod;
    logic [7:0] r_col;
    logic [PAGE_W-1:0] r_page, r_page_last;
    logic r_col_on;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [PAGE_W-1:0] r_ref_page;
    logic [SLOT_W-1:0] r_ref_slot;

    logic [7:0] r_out_byte;
    logic r_is_data, r_frame_end, r_valid;

    logic [8:0] x_sum, y_sum;
    logic [7:0] x_end_n, y_end_n;
    logic [7:0] span, inner;
    logic [PCT_W-1:0] pct_sat;
    logic [7:0] col_off;
    logic col_on_n;
    logic bar_last, clr_last;
    logic [ADDR_W-1:0] pix_addr, bar_addr, ref_addr, mem_addr;
    logic [SLOT_W-1:0] ref_col;
    logic ref_is_data, ref_last_slot, ref_last_page;
    logic [7:0] pix_mask, wr_data, bar_data, ref_byte;
    logic mem_we;

    // item checks straight from the ports, sampled by the controller on accept
    always_comb begin
        o_status.pix_ok = ({1'b0, i_pos_x} < 9'(DISPLAY_WIDTH)) &&
                          ({1'b0, i_pos_y} < 9'(DISPLAY_HEIGHT));
        o_status.bar_ok = o_status.pix_ok && (i_bar_width >= 8'd2) &&
                          (i_bar_height >= 8'd2);
        o_status.clr_last = clr_last;
        o_status.bar_last = bar_last;
    end

    // clipping of the bar to the display
    assign x_sum   = {1'b0, r_x} + {1'b0, r_w};
    assign y_sum   = {1'b0, r_y} + {1'b0, r_h};
    assign x_end_n = (x_sum > 9'(DISPLAY_WIDTH))  ? 8'(DISPLAY_WIDTH - 1)  : 8'(x_sum - 9'd1);
    assign y_end_n = (y_sum > 9'(DISPLAY_HEIGHT)) ? 8'(DISPLAY_HEIGHT - 1) : 8'(y_sum - 9'd1);

    // fill threshold: column i is filled when i * 100 <= (w - 2) * pct
    assign span    = r_x_end - r_x;
    assign inner   = (span == 8'd0) ? 8'd0 : span - 8'd1;
    assign pct_sat = (r_pct > 8'(FULL_PERCENT)) ? FULL_PERCENT : r_pct[PCT_W-1:0];
    assign col_off = r_col - r_x;
    assign col_on_n = (r_col == r_x) || (r_col == r_x_end) ||
                      (PROD_W'(col_off) * PROD_W'(FULL_PERCENT) <= r_prod);

    assign bar_last = (r_col == r_x_end) && (r_page == r_page_last);
    assign clr_last = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));

    // addresses
    assign ref_is_data   = (r_ref_slot >= SLOT_W'(CMD_SLOTS));
    assign ref_col       = r_ref_slot - SLOT_W'(CMD_SLOTS);
    assign ref_last_slot = (r_ref_slot == SLOT_W'(SLOT_COUNT - 1));
    assign ref_last_page = (r_ref_page == PAGE_W'(PAGE_COUNT - 1));

    assign pix_addr = ADDR_W'(r_y >> 3) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(r_x);
    assign bar_addr = ADDR_W'(r_page) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(r_col);
    assign ref_addr = ref_is_data ?
                      ADDR_W'(r_ref_page) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(ref_col) :
                      '0;

    always_comb begin
        priority if (i_cmd.clr_wr) begin
            mem_addr = r_clr_addr;
        end else if (i_cmd.op == CMD_BAR) begin
            mem_addr = bar_addr;
        end else if (i_cmd.op == CMD_NEXT_BYTE) begin
            mem_addr = ref_addr;
        end else begin
            mem_addr = pix_addr;
        end
    end

    // byte update for the bar: rows of the bar take border or fill, others keep
    always_comb begin
        logic [8:0] row;
        logic       in_rows;
        logic       row_border;
        bar_data = r_rd_data;
        for (int b = 0; b < PAGE_ROWS; b++) begin
            row        = 9'({r_page, 3'(b)});
            in_rows    = (row >= {1'b0, r_y}) && (row <= {1'b0, r_y_end});
            row_border = (row == {1'b0, r_y}) || (row == {1'b0, r_y_end});
            if (in_rows) begin
                bar_data[b] = r_col_on || row_border;
            end
        end
    end

    assign pix_mask = 8'd1 << r_y[2:0];

    always_comb begin
        unique case (i_cmd.op)
            CMD_SET_PIXEL: wr_data = r_rd_data | pix_mask;
            CMD_CLR_PIXEL: wr_data = r_rd_data & ~pix_mask;
            CMD_BAR:       wr_data = bar_data;
            default:       wr_data = r_rd_data;
        endcase
    end

    assign mem_we = i_cmd.clr_wr || i_cmd.mem_wr;

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= i_cmd.clr_wr ? 8'd0 : wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_store[mem_addr];
        end
    end

    // refresh byte selection
    always_comb begin
        unique case (r_ref_slot)
            SLOT_W'(0): ref_byte = PAGE_CMD_BASE + 8'(r_ref_page);
            SLOT_W'(1): ref_byte = COL_LOW_CMD;
            SLOT_W'(2): ref_byte = COL_HIGH_CMD;
            default:    ref_byte = r_rd_data;
        endcase
    end

    // item and bar walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
            r_w   <= i_bar_width;
            r_h   <= i_bar_height;
            r_pct <= i_fill_percent;
        end
        if (i_cmd.clip) begin
            r_x_end <= x_end_n;
            r_y_end <= y_end_n;
        end
        if (i_cmd.prod) begin
            r_prod      <= PROD_W'(inner) * PROD_W'(pct_sat);
            r_col       <= r_x;
            r_page      <= PAGE_W'(r_y >> 3);
            r_page_last <= PAGE_W'(r_y_end >> 3);
        end
        if (i_cmd.mem_rd) begin
            r_col_on <= col_on_n;
        end
        if (i_cmd.mem_wr && (i_cmd.op == CMD_BAR)) begin
            if (r_col == r_x_end) begin
                r_col  <= r_x;
                r_page <= r_page + PAGE_W'(1);
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
        if (i_cmd.ref_out) begin
            r_out_byte  <= ref_byte;
            r_is_data   <= ref_is_data;
            r_frame_end <= ref_last_slot && ref_last_page;
        end
    end

    // control state: clearing pass counter, refresh position, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_ref_page <= '0;
            r_ref_slot <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.ref_out;
            if (i_cmd.clr_wr) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.ref_out) begin
                if (ref_last_slot) begin
                    r_ref_slot <= '0;
                    r_ref_page <= ref_last_page ? '0 : r_ref_page + PAGE_W'(1);
                end else begin
                    r_ref_slot <= r_ref_slot + SLOT_W'(1);
                end
            end
        end
    end

    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_is_data;
    assign o_frame_end = r_frame_end;
    assign o_valid     = r_valid;

    `ASSERT_STD(a_bar_col_in_range, (i_cmd.mem_wr && i_cmd.op == CMD_BAR) |-> (r_col >= r_x && r_col <= r_x_end), "bar walk outside its columns")
    `ASSERT_STD(a_ref_slot_range, r_ref_slot <= SLOT_W'(SLOT_COUNT - 1), "refresh slot beyond end of page")

endmodule

/* rtl/mpfe_ctrl.sv */
// ----------------------------------------------------------------------------
// mpfe_ctrl
// sequencer for clear pass, pixel and bar read-modify-write, refresh reads
// ----------------------------------------------------------------------------
module mpfe_ctrl import mpfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_command,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CLIP   = 3'd2;
    localparam logic [2:0] S_PROD   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_REFOUT = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_op, n_op;

    always_comb begin
        o_cmd    = '0;
        o_cmd.op = r_op;
        n_state  = r_state;
        n_op     = r_op;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_command;
                    unique case (i_command)
                        CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
                            if (i_status.pix_ok) begin
                                n_state = S_READ;
                            end
                        end
                        CMD_CLEAR_ALL: n_state = S_CLEAR;
                        CMD_BAR: begin
                            if (i_status.bar_ok) begin
                                n_state = S_CLIP;
                            end
                        end
                        CMD_NEXT_BYTE: n_state = S_READ;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = (r_op == CMD_NEXT_BYTE) ? S_REFOUT : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.mem_wr = 1'b1;
                if ((r_op == CMD_BAR) && !i_status.bar_last) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REFOUT: begin
                o_cmd.ref_out = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= CMD_SET_PIXEL;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/mono_page_framebuffer_engine.sv */
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine
// one-bit-per-pixel page-mode frame store with pixel, clear, bar and refresh
// ----------------------------------------------------------------------------
//  channel  | direction | transfer when       | payload
//  ---------+-----------+---------------------+----------------------------------
//  command  | in        | start high, busy low| command, pos_x/y, bar size, percent
//  result   | out       | o_valid high        | out_byte, is_data, frame_end
//
//  set/clear pixel and next refresh byte: each item steps through a read, then
//  a modify or an output, then back to idle
//  refresh byte reaches the result ports through the READ and REFOUT states
//  clear all: one store byte written per cycle over all 1024 store bytes
//  progress bar: clip and product steps, then a read and a write per touched store byte (pages x clipped columns)
//  after reset a clearing pass over all 1024 store bytes runs with busy high
//  results cannot be stalled; a finished result never blocks the next item
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_page_framebuffer_engine import mpfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_command,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_bar_width,
    input  logic [7:0] i_bar_height,
    input  logic [7:0] i_fill_percent,
    // result channel, one-cycle strobe
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_end
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       next_byte_xfer;

    // sequencer: owns the state and the latched command code
    mpfe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy)
    );

    // frame store, walk counters and refresh position
    mpfe_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_bar_width    (i_bar_width),
        .i_bar_height   (i_bar_height),
        .i_fill_percent (i_fill_percent),
        .o_out_byte     (o_out_byte),
        .o_is_data      (o_is_data),
        .o_frame_end    (o_frame_end),
        .o_valid        (o_valid)
    );

    // refresh command taken on this edge
    assign next_byte_xfer = start && !busy && (i_command == CMD_NEXT_BYTE);

    // a refresh transfer yields its byte through the READ and REFOUT states and the output register
    `ASSERT_STD(a_next_byte_latency, next_byte_xfer |-> ##3 o_valid, "refresh byte late")
    // a result strobe is never directly followed by another
    `ASSERT_STD(a_valid_spacing, o_valid |=> !o_valid, "back-to-back result strobes")

endmodule

/* tb/sv/mono_page_framebuffer_engine_test.sv */
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_test
// self-checking bench for the page-mode frame store: drives pixel, clear,
// progress bar, refresh-byte and unused commands, mirrors the store and the refresh
// position in a local image and checks each refresh byte against it
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine_test import mpfe_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // codes with no function in the block, used to prove they are ignored
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_CODE    = 3'd7;

    localparam int MAX_GAP     = 15;
    localparam int DRAIN_LIMIT = 4096;
    localparam int TAIL_CYCLES = 8;

    // one command transfer
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] bar_width;
        logic [7:0] bar_height;
        logic [7:0] fill_percent;
    } t_fb_item;

    // one refresh stream byte as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } t_refresh_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_command;
    logic [7:0] i_pos_x;
    logic [7:0] i_pos_y;
    logic [7:0] i_bar_width;
    logic [7:0] i_bar_height;
    logic [7:0] i_fill_percent;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       o_frame_end;

    // local image of the frame store and of the refresh position
    logic [7:0]    shadow_store [STORE_DEPTH];
    int            scan_page;
    int            scan_slot;
    t_refresh_byte pending_bytes [$];

    int error_count;
    int refresh_sent;
    bit gapless;

    mono_page_framebuffer_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_bar_width    (i_bar_width),
        .i_bar_height   (i_bar_height),
        .i_fill_percent (i_fill_percent),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_is_data      (o_is_data),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hang guard, far above the slowest legal run of this stimulus
    initial begin
        #20_000_000;
        $display("mono_page_framebuffer_engine_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // pixels off the display are dropped; top row of a page is bit 0
    function automatic void plot_pixel(int x, int y, bit on);
        int         idx;
        logic [7:0] mask;
        if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT)
            return;
        idx  = (y / PAGE_ROWS) * DISPLAY_WIDTH + x;
        mask = 8'(1 << (y % PAGE_ROWS));
        if (on)
            shadow_store[idx] = shadow_store[idx] | mask;
        else
            shadow_store[idx] = shadow_store[idx] & ~mask;
    endfunction

    // clipped bar: border first, then interior columns up to the fill point
    function automatic void paint_bar(int x, int y, int w, int h, int pct);
        int fill;
        if (w < 2 || h < 2 || x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT)
            return;
        if (x + w > DISPLAY_WIDTH)
            w = DISPLAY_WIDTH - x;
        if (y + h > DISPLAY_HEIGHT)
            h = DISPLAY_HEIGHT - y;
        if (pct > int'(FULL_PERCENT))
            pct = int'(FULL_PERCENT);
        for (int i = 0; i < w; i++) begin
            plot_pixel(x + i, y, 1'b1);
            plot_pixel(x + i, y + h - 1, 1'b1);
        end
        for (int j = 0; j < h; j++) begin
            plot_pixel(x, y + j, 1'b1);
            plot_pixel(x + w - 1, y + j, 1'b1);
        end
        // a dimension clipped down to one pixel leaves only the border
        if (w < 2 || h < 2)
            return;
        fill = ((w - 2) * pct) / int'(FULL_PERCENT);
        for (int i = 1; i + 1 < w; i++)
            for (int j = 1; j + 1 < h; j++)
                plot_pixel(x + i, y + j, i <= fill);
    endfunction

    // three command bytes per page, then one data byte per column
    function automatic t_refresh_byte next_refresh_byte();
        t_refresh_byte rb;
        rb = '0;
        if (scan_slot == 0) begin
            rb.out_byte = PAGE_CMD_BASE + 8'(scan_page);
        end else if (scan_slot == 1) begin
            rb.out_byte = COL_LOW_CMD;
        end else if (scan_slot == 2) begin
            rb.out_byte = COL_HIGH_CMD;
        end else begin
            rb.out_byte = shadow_store[scan_page * DISPLAY_WIDTH + scan_slot - CMD_SLOTS];
            rb.is_data  = 1'b1;
        end
        scan_slot++;
        if (scan_slot >= SLOT_COUNT) begin
            scan_slot = 0;
            scan_page++;
            // wrap back to page 0 after the last data byte of the frame
            if (scan_page >= PAGE_COUNT) begin
                scan_page    = 0;
                rb.frame_end = 1'b1;
            end
        end
        return rb;
    endfunction

    function automatic void apply_item(t_fb_item it);
        case (it.command)
            CMD_SET_PIXEL: plot_pixel(it.pos_x, it.pos_y, 1'b1);
            CMD_CLR_PIXEL: plot_pixel(it.pos_x, it.pos_y, 1'b0);
            CMD_CLEAR_ALL: begin
                foreach (shadow_store[k])
                    shadow_store[k] = '0;
            end
            CMD_BAR: paint_bar(it.pos_x, it.pos_y, it.bar_width, it.bar_height,
                               it.fill_percent);
            CMD_NEXT_BYTE: begin
                pending_bytes.push_back(next_refresh_byte());
                refresh_sent++;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking: the strobe cannot be held off, so every pulse is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_refresh_byte want;
        if (i_rst_n && o_valid) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected refresh byte %02h (is_data %0b, frame_end %0b)",
                       o_out_byte, o_is_data, o_frame_end);
                error_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, o_out_byte);
                    error_count++;
                end
                if (o_is_data !== want.is_data) begin
                    $error("is_data: expected %0b, got %0b", want.is_data, o_is_data);
                    error_count++;
                end
                if (o_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, o_frame_end);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_fb_item make_item(logic [2:0] cmd, int x, int y, int w, int h,
                                           int pct);
        t_fb_item it;
        it.command      = cmd;
        it.pos_x        = 8'(x);
        it.pos_y        = 8'(y);
        it.bar_width    = 8'(w);
        it.bar_height   = 8'(h);
        it.fill_percent = 8'(pct);
        return it;
    endfunction

    // called on a rising edge; returns on a rising edge after the transfer
    // and the sender's own pause; start stays high when no pause follows
    task automatic send_item(input t_fb_item it);
        int gap;
        i_command      <= it.command;
        i_pos_x        <= it.pos_x;
        i_pos_y        <= it.pos_y;
        i_bar_width    <= it.bar_width;
        i_bar_height   <= it.bar_height;
        i_fill_percent <= it.fill_percent;
        start          <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        // transfer happened at this edge
        apply_item(it);
        gap = gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random content; don't-care fields are left at full range on purpose
    function automatic t_fb_item random_item(int refresh_pct);
        t_fb_item it;
        int       pick;
        it.command      = CMD_NEXT_BYTE;
        it.pos_x        = 8'($urandom_range(0, 255));
        it.pos_y        = 8'($urandom_range(0, 255));
        it.bar_width    = 8'($urandom_range(0, 255));
        it.bar_height   = 8'($urandom_range(0, 255));
        it.fill_percent = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < refresh_pct)
            return it;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            it.command = (pick < 40) ? CMD_SET_PIXEL : CMD_CLR_PIXEL;
            // mostly on the display, now and then anywhere in the byte range
            if ($urandom_range(0, 4) != 0) begin
                it.pos_x = 8'($urandom_range(0, DISPLAY_WIDTH - 1));
                it.pos_y = 8'($urandom_range(0, DISPLAY_HEIGHT - 1));
            end
        end else if (pick < 63) begin
            it.command = CMD_CLEAR_ALL;
        end else if (pick < 67) begin
            it.command = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
        end else begin
            it.command = CMD_BAR;
            if ($urandom_range(0, 9) != 0) begin
                // small bars near or just past the edges keep the run short
                it.pos_x      = 8'($urandom_range(0, DISPLAY_WIDTH + 7));
                it.pos_y      = 8'($urandom_range(0, DISPLAY_HEIGHT + 3));
                it.bar_width  = 8'($urandom_range(0, 24));
                it.bar_height = 8'($urandom_range(0, 20));
            end else begin
                // rare large bar, size left at full range and clipped
                it.pos_x = 8'($urandom_range(0, 40));
                it.pos_y = 8'($urandom_range(0, 24));
            end
            if ($urandom_range(0, 1) != 0)
                it.fill_percent = 8'($urandom_range(0, int'(FULL_PERCENT)));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_pixels();
        send_item(make_item(CMD_SET_PIXEL, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SET_PIXEL, DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 0, 0, 0));
        // just off the right edge, just below the bottom, far corner
        send_item(make_item(CMD_SET_PIXEL, DISPLAY_WIDTH, 5, 0, 0, 0));
        send_item(make_item(CMD_SET_PIXEL, 5, DISPLAY_HEIGHT, 0, 0, 0));
        send_item(make_item(CMD_SET_PIXEL, 255, 255, 255, 255, 255));
        send_item(make_item(CMD_CLR_PIXEL, DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 0, 0, 0));
        send_item(make_item(CMD_SET_PIXEL, 64, 33, 0, 0, 0));
    endtask

    task automatic test_clear_all();
        send_item(make_item(CMD_SET_PIXEL, 2, 7, 0, 0, 0));
        send_item(make_item(CMD_CLEAR_ALL, 255, 255, 255, 255, 255));
    endtask

    task automatic test_bars();
        // rejected: too narrow, too flat, origin off the display
        send_item(make_item(CMD_BAR, 10, 10, 1, 10, 50));
        send_item(make_item(CMD_BAR, 10, 10, 10, 1, 50));
        send_item(make_item(CMD_BAR, DISPLAY_WIDTH, 0, 20, 8, 50));
        // whole display, full fill
        send_item(make_item(CMD_BAR, 0, 0, DISPLAY_WIDTH, DISPLAY_HEIGHT, 100));
        send_item(make_item(CMD_BAR, 10, 10, 20, 10, 0));
        send_item(make_item(CMD_BAR, 30, 40, 40, 12, 50));
        // clipped on both axes with the percentage saturating
        send_item(make_item(CMD_BAR, DISPLAY_WIDTH - 8, DISPLAY_HEIGHT - 4, 255, 255, 255));
        // width clipped to one column: border only
        send_item(make_item(CMD_BAR, DISPLAY_WIDTH - 1, 20, 5, 6, 50));
    endtask

    task automatic test_unused_commands();
        send_item(make_item(CMD_FIRST_UNUSED, 1, 1, 0, 0, 0));
        send_item(make_item(CMD_LAST_CODE, 255, 255, 255, 255, 255));
    endtask

    task automatic test_refresh_commands();
        // page address, column low, column high, first data column
        repeat (CMD_SLOTS + 1)
            send_item(make_item(CMD_NEXT_BYTE, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_drawing();
        for (int n = 0; n < 50; n++) begin
            if (n % 40 == 0)
                gapless = ($urandom_range(0, 2) == 0);
            send_item(random_item(20));
        end
    endtask

    // refresh-heavy traffic with drawing mixed in, long enough to pass the
    // end of a frame and start the next one
    task automatic test_refresh_sweep();
        int n;
        n = 0;
        while (refresh_sent < PAGE_COUNT * SLOT_COUNT + 8) begin
            if (n % 40 == 0)
                gapless = ($urandom_range(0, 2) == 0);
            send_item(random_item(96));
            n++;
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while ((pending_bytes.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            $error("%0d refresh bytes never arrived", pending_bytes.size());
            error_count += pending_bytes.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        error_count  = 0;
        refresh_sent = 0;
        gapless      = 1'b0;
        scan_page    = 0;
        scan_slot    = 0;
        foreach (shadow_store[k])
            shadow_store[k] = '0;

        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_command      <= CMD_SET_PIXEL;
        i_pos_x        <= '0;
        i_pos_y        <= '0;
        i_bar_width    <= '0;
        i_bar_height   <= '0;
        i_fill_percent <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // one more edge so busy reflects the state after reset; the clearing
        // pass that follows is covered by waiting on busy
        @(posedge i_clk);

        test_pixels();
        test_clear_all();
        test_bars();
        test_unused_commands();
        test_refresh_commands();
        test_random_drawing();
        test_refresh_sweep();
        drain_results();

        if (error_count == 0)
            $display("mono_page_framebuffer_engine_test: done, clean");
        else
            $display("mono_page_framebuffer_engine_test: done, errors");
        $finish;
    end

endmodule
